// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define SB_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define SB_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sb16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sb16_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = 16;
  localparam int WORD_W = LANES * LANE_W;

  // lane pipeline depth plus merge depth
  localparam int LANE_STAGES  = 8;
  localparam int MERGE_STAGES = 3;
  localparam int LATENCY      = LANE_STAGES + MERGE_STAGES;

  localparam logic [31:0] GOLD32 = 32'h9e37_79b9;
  localparam logic [31:0] MUL_A  = 32'h85eb_ca6b;
  localparam logic [31:0] MUL_B  = 32'hc2b2_ae35;

  localparam logic [15:0] PIVOT    = 16'd32749;
  localparam logic [15:0] FULL16   = 16'hFFFF;
  localparam logic [15:0] DIV_HIGH = 16'd32786;  // FULL16 - PIVOT
  localparam logic [15:0] POLY_A   = 16'd40503;
  localparam logic [15:0] POLY_B   = 16'd11467;

  // floor(2^32 / divisor); quotient estimate is exact or one short
  localparam logic [17:0] RECIP_LOW  = 18'd131148;
  localparam logic [17:0] RECIP_HIGH = 18'd131000;

  localparam logic [63:0] GOLD64 = 64'h9E37_79B9_7F4A_7C15;

  localparam int ROT_A = 13;
  localparam int ROT_B = 37;

endpackage

`default_nettype wire

// File: design/sb16_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module sb16_lane (
  input  wire logic                       clk,
  input  wire logic                       map_mode,
  input  wire logic [sb16_pkg::LANE_W-1:0] lane,
  output logic      [sb16_pkg::LANE_W-1:0] sbox
);
  import sb16_pkg::*;

  logic [31:0] x_add, a_in;
  logic [31:0] s1_a, s2_b, s3_c, s4_m;
  logic [31:0] c_xs, mul_a, mul_b;

  logic [15:0] v4, base4;
  logic        lt4;

  logic [31:0] s5_n, s5_pa;
  logic [15:0] s5_v, s5_mh;
  logic        s5_lt;

  logic [17:0] recip;
  logic [49:0] prod_r;
  logic [31:0] poly_pp;
  logic [15:0] s6_q, s6_v, s6_mh;
  logic [31:0] s6_n, s6_pp;
  logic        s6_lt;

  logic [15:0] div6;
  logic [31:0] s7_qd, s7_n;
  logic [15:0] s7_q, s7_mh, s7_poly, poly_sum;
  logic        s7_lt;

  logic [15:0] div7, q_fix;
  logic [31:0] rem;

  always_comb begin
    x_add = {16'b0, lane} + GOLD32;
    a_in  = x_add ^ (x_add >> 16);
    mul_a = s1_a * MUL_A;
    c_xs  = s2_b ^ (s2_b >> 13);
    mul_b = c_xs * MUL_B;
  end

  always_ff @(posedge clk) begin
    s1_a <= a_in;
    s2_b <= mul_a;
    s3_c <= mul_b;
    s4_m <= s3_c ^ (s3_c >> 16);
  end

  // numerator of the tent map is base * 65535, built by shift and subtract
  always_comb begin
    v4    = s4_m[15:0];
    lt4   = v4 < PIVOT;
    base4 = lt4 ? v4 : (FULL16 - v4);
  end

  always_ff @(posedge clk) begin
    s5_n  <= {base4, 16'b0} - {16'b0, base4};
    s5_lt <= lt4;
    s5_v  <= v4;
    s5_mh <= s4_m[31:16];
    s5_pa <= {16'b0, POLY_A} * {16'b0, v4};
  end

  always_comb begin
    recip   = s5_lt ? RECIP_LOW : RECIP_HIGH;
    prod_r  = {18'b0, s5_n} * {32'b0, recip};
    poly_pp = s5_pa * {16'b0, FULL16 - s5_v};
  end

  always_ff @(posedge clk) begin
    s6_q  <= prod_r[47:32];
    s6_pp <= poly_pp;
    s6_n  <= s5_n;
    s6_lt <= s5_lt;
    s6_v  <= s5_v;
    s6_mh <= s5_mh;
  end

  always_comb begin
    div6     = s6_lt ? PIVOT : DIV_HIGH;
    poly_sum = s6_v + s6_pp[31:16] + POLY_B + {1'b0, s6_mh[15:1]};
  end

  always_ff @(posedge clk) begin
    s7_qd   <= {16'b0, s6_q} * {16'b0, div6};
    s7_q    <= s6_q;
    s7_n    <= s6_n;
    s7_lt   <= s6_lt;
    s7_mh   <= s6_mh;
    s7_poly <= poly_sum;
  end

  // bump the estimate once when the remainder still reaches the divisor
  always_comb begin
    div7  = s7_lt ? PIVOT : DIV_HIGH;
    rem   = s7_n - s7_qd;
    q_fix = s7_q + {15'b0, (rem >= {16'b0, div7})};
  end

  always_ff @(posedge clk) begin
    sbox <= map_mode ? (q_fix ^ s7_mh) : s7_poly;
  end

endmodule

`default_nettype wire

// File: design/sb16_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module sb16_merge (
  input  wire logic                       clk,
  input  wire logic [sb16_pkg::WORD_W-1:0] lanes,
  output logic      [sb16_pkg::WORD_W-1:0] mixed
);
  import sb16_pkg::*;

  logic [WORD_W-1:0] z_a, z_b, s1_z;
  logic [63:0]       ll;
  logic [63:0]       lh, hl;
  logic [63:0]       s2_ll;
  logic [31:0]       s2_lh, s2_hl;

  always_comb begin
    z_a = lanes ^ {lanes[WORD_W-ROT_A-1:0], lanes[WORD_W-1:WORD_W-ROT_A]};
    z_b = z_a ^ {z_a[WORD_W-ROT_B-1:0], z_a[WORD_W-1:WORD_W-ROT_B]};
  end

  always_ff @(posedge clk) begin
    s1_z <= z_b;
  end

  // 64 x 64 product modulo 2^64 from three 32 x 32 partial products
  always_comb begin
    ll = {32'b0, s1_z[31:0]}  * {32'b0, GOLD64[31:0]};
    lh = {32'b0, s1_z[31:0]}  * {32'b0, GOLD64[63:32]};
    hl = {32'b0, s1_z[63:32]} * {32'b0, GOLD64[31:0]};
  end

  always_ff @(posedge clk) begin
    s2_ll <= ll;
    s2_lh <= lh[31:0];
    s2_hl <= hl[31:0];
  end

  always_ff @(posedge clk) begin
    mixed <= {s2_ll[63:32] + s2_lh + s2_hl, s2_ll[31:0]};
  end

endmodule

`default_nettype wire

// File: design/sbox16_lane_mix_hash_top.sv
`timescale 1ns / 1ps
`default_nettype none

// 64-bit word mixer: four 16-bit S-box lanes, rotate-xor, golden-ratio multiply.
// Input: raise start with data_word; the word transfers at an edge where start is
// high and busy is low. busy is high only while rst is high.
// Output: done is high for one cycle with mixed_word; the receiver cannot stall,
// so each result must be taken in the cycle it is shown.
// Pipeline stages from the accepting edge to the result register of done:
// eight in each lane (two mix multiplies, the tent-map reciprocal divide with its
// correction step) and three in the merge (rotate-xor, split 64-bit multiply).
// Throughput: one word per cycle while busy is low; every stage is a plain pipeline register.
// Configuration: cfg_data bit sets map_mode (0 polynomial, 1 tent) on a cfg_valid
// and cfg_ready transfer; write it only while no word is in flight.
// Reset: synchronous, clears map_mode to polynomial and drops words in flight.
module sbox16_lane_mix_hash_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [sb16_pkg::WORD_W-1:0] data_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_data,
  output logic                            done,
  output logic      [sb16_pkg::WORD_W-1:0] mixed_word
);
  import sb16_pkg::*;

  logic              map_mode;
  logic [LATENCY-1:0] vld;
  logic [WORD_W-1:0]  lane_out;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign done      = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      map_mode <= cfg_data;
    end
  end

  // advance the valid marks alongside the payload pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start && !busy};
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    sb16_lane u_lane (
      .clk      (clk),
      .map_mode (map_mode),
      .lane     (data_word[k*LANE_W +: LANE_W]),
      .sbox     (lane_out[k*LANE_W +: LANE_W])
    );
  end

  sb16_merge u_merge (
    .clk   (clk),
    .lanes (lane_out),
    .mixed (mixed_word)
  );

endmodule

`default_nettype wire

// File: design/sb16_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sb16_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic [sb16_pkg::WORD_W-1:0] mixed_word
);
  import sb16_pkg::*;

  // each transfer in gives a result a fixed latency later, and only then
  `SB_ASSERT_RST(a_in_to_out, clk, rst, (start && !busy) |-> ##LATENCY done, "result missing")
  `SB_ASSERT_RST(a_out_from_in, clk, rst, done |-> $past(start && !busy, LATENCY), "stray result")
  `SB_ASSERT_ALL(a_rst_drop, clk, rst |=> !done, "result after reset")
  `SB_ASSERT_RST(a_out_known, clk, rst, done |-> !$isunknown(mixed_word), "unknown result")

endmodule

bind sbox16_lane_mix_hash_top sb16_chk u_sb16_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .mixed_word (mixed_word)
);

`default_nettype wire

// File: tb/sv/sbox16_lane_mix_hash_tb_pkg.sv
`timescale 1ns / 1ps

package sbox16_lane_mix_hash_tb_pkg;

  // S-box generator selected by the single configuration register
  typedef enum logic {
    MAP_POLY = 1'b0,
    MAP_TENT = 1'b1
  } map_mode_e;

endpackage

// File: tb/sv/sbox16_lane_mix_hash_checker.sv
`timescale 1ns / 1ps

module sbox16_lane_mix_hash_checker
  import sbox16_lane_mix_hash_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] data_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        done,
  input  logic [63:0] mixed_word,
  output int          mismatches,
  output int          in_flight,
  output int          words_checked
);

  localparam logic [31:0] MIX_OFFSET = 32'h9e37_79b9;
  localparam logic [31:0] MIX_MUL_1  = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_MUL_2  = 32'hc2b2_ae35;
  localparam logic [31:0] TENT_PIVOT = 32'd32749;
  localparam logic [31:0] LANE_FULL  = 32'd65535;
  localparam logic [31:0] POLY_MUL   = 32'd40503;
  localparam logic [31:0] POLY_ADD   = 32'd11467;
  localparam logic [63:0] WORD_MUL   = 64'h9E37_79B9_7F4A_7C15;

  map_mode_e   map_mode;
  logic [63:0] expected_words[$];
  int          fail_total;
  int          checked_total;

  function automatic logic [15:0] sbox_lane(input logic [15:0] lane, input map_mode_e mode);
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] t;
    logic [31:0] prod;
    logic [31:0] sum;
    m = {16'h0000, lane} + MIX_OFFSET;
    m = m ^ (m >> 16);
    m = m * MIX_MUL_1;
    m = m ^ (m >> 13);
    m = m * MIX_MUL_2;
    m = m ^ (m >> 16);
    v = {16'h0000, m[15:0]};
    if (mode == MAP_TENT) begin
      // rising edge below the pivot, falling edge above it
      if (v < TENT_PIVOT)
        t = (v * LANE_FULL) / TENT_PIVOT;
      else
        t = ((LANE_FULL - v) * LANE_FULL) / (LANE_FULL - TENT_PIVOT);
      return t[15:0] ^ m[31:16];
    end else begin
      prod = POLY_MUL * v;
      prod = prod * (LANE_FULL - v);
      sum  = v + (prod >> 16) + POLY_ADD + (m >> 17);
      return sum[15:0];
    end
  endfunction

  function automatic logic [63:0] predict_mixed_word(input logic [63:0] word,
                                                     input map_mode_e mode);
    logic [63:0] y;
    y = {sbox_lane(word[63:48], mode), sbox_lane(word[47:32], mode),
         sbox_lane(word[31:16], mode), sbox_lane(word[15:0], mode)};
    y = y ^ {y[50:0], y[63:51]};
    y = y ^ {y[26:0], y[63:27]};
    y = y * WORD_MUL;
    return y;
  endfunction

  initial begin
    map_mode      = MAP_POLY;
    fail_total    = 0;
    checked_total = 0;
    mismatches    = 0;
    in_flight     = 0;
    words_checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      map_mode = MAP_POLY;
      expected_words.delete();
    end else begin
      // retire the result first, then queue any word taken at this edge
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("mixed_word arrived with nothing outstanding: got %h", mixed_word);
          fail_total++;
        end else begin
          if (mixed_word !== expected_words[0]) begin
            $error("mixed_word mismatch: expected %h, got %h", expected_words[0], mixed_word);
            fail_total++;
          end
          void'(expected_words.pop_front());
          checked_total++;
        end
      end
      if (cfg_valid && cfg_ready)
        map_mode = map_mode_e'(cfg_data);
      if (start && !busy)
        expected_words.push_back(predict_mixed_word(data_word, map_mode));
    end
    mismatches    <= fail_total;
    in_flight     <= expected_words.size();
    words_checked <= checked_total;
  end

endmodule

// File: tb/sv/sbox16_lane_mix_hash_top_tb.sv
`timescale 1ns / 1ps

module sbox16_lane_mix_hash_top_tb;
  import sbox16_lane_mix_hash_tb_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_PHASES   = 5;
  localparam int WORDS_PER_PHASE = 250;
  localparam int DIRECTED_COUNT  = 12;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] data_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        done;
  logic [63:0] mixed_word;

  int mismatches;
  int in_flight;
  int words_checked;
  int mode_writes;
  bit idle_on;
  int burst_left;

  logic [63:0] directed_words[DIRECTED_COUNT] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_FFFF_0000_FFFF, 64'hFFFF_0000_FFFF_0000,
    64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
    64'h0001_0001_0001_0001, 64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0001,
    64'h0123_4567_89AB_CDEF, 64'h7FED_7FEC_7FEE_8012
  };

  sbox16_lane_mix_hash_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .data_word  (data_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .mixed_word (mixed_word)
  );

  sbox16_lane_mix_hash_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .data_word     (data_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .mixed_word    (mixed_word),
    .mismatches    (mismatches),
    .in_flight     (in_flight),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sbox16_lane_mix_hash_top test failed");
    $finish;
  end

  // hold start between back-to-back words; only drop it when a gap is drawn
  task automatic send_word(input logic [63:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      idle_on    = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(10, 60);
    end
    burst_left--;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    data_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input map_mode_e mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    int          k;
    w = '0;
    case ($urandom_range(0, 3))
      0: w = {$urandom, $urandom};
      1: begin
        // lanes drawn from the extremes and random values
        for (k = 0; k < 4; k++) begin
          case ($urandom_range(0, 2))
            0: w[16*k +: 16] = 16'h0000;
            1: w[16*k +: 16] = 16'hFFFF;
            default: w[16*k +: 16] = 16'($urandom);
          endcase
        end
      end
      2: begin
        w = 64'h1 << $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 1)
          w = ~w;
      end
      default: w = {48'h0, 16'($urandom)} << (16 * $urandom_range(0, 3));
    endcase
    return w;
  endfunction

  initial begin
    int i;
    int p;
    start       <= 1'b0;
    data_word   <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= 1'b0;
    rst         <= 1'b1;
    mode_writes = 0;
    idle_on     = 1'b0;
    burst_left  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under the reset mode, then under the tent map
    for (i = 0; i < DIRECTED_COUNT; i++)
      send_word(directed_words[i]);
    drain_pipeline();
    write_mode(MAP_TENT);
    for (i = 0; i < DIRECTED_COUNT; i++)
      send_word(directed_words[i]);
    drain_pipeline();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_mode((p % 2 == 0) ? MAP_POLY : MAP_TENT);
      for (i = 0; i < WORDS_PER_PHASE; i++)
        send_word(random_word());
      drain_pipeline();
    end

    $display("Run covered %0d words checked over %0d map_mode writes (both maps).",
             words_checked, mode_writes);
    if (mismatches == 0) begin
      $display("sbox16_lane_mix_hash_top test passed");
    end else begin
      $display("sbox16_lane_mix_hash_top test failed");
    end
    $finish;
  end

endmodule
